### rtl/pidr_pkg.sv
`timescale 1ns / 1ps

package pidr_pkg;

    localparam int ENC_CLAMP_MAX = 8500;
    localparam int LEAK_DIVISOR  = 10;

    localparam int DIV_W   = 36;
    localparam int DVSR_W  = 16;
    localparam int CNT_W   = 6;
    localparam int MUL_W   = 17;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 36;
    localparam int REF_W   = 22;
    localparam int MAG_W   = 15;
    localparam int LEAK_W  = 14;

    localparam logic [15:0] LEAK_RECIP = 16'd52429;
    localparam int          LEAK_SHIFT = 19;

    localparam int REF_STEPS   = REF_W;
    localparam int TOTAL_STEPS = DIV_W;

    typedef enum logic [2:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_OUTPUT_LIMIT   = 3'd3,
        REG_SCALE_DIVISOR  = 3'd4,
        REG_ENCODER_FS     = 3'd5,
        REG_JOYSTICK_FS    = 3'd6,
        REG_DEADZONE       = 3'd7
    } reg_index_t;

    localparam logic [14:0] GAIN_P_RESET        = 15'd10;
    localparam logic [14:0] GAIN_I_RESET        = 15'd6;
    localparam logic [14:0] GAIN_D_RESET        = 15'd1;
    localparam logic [14:0] OUTPUT_LIMIT_RESET  = 15'd4095;
    localparam logic [15:0] SCALE_DIVISOR_RESET = 16'd100;
    localparam logic [13:0] ENCODER_FS_RESET    = 14'd8500;
    localparam logic [7:0]  JOYSTICK_FS_RESET   = 8'd255;
    localparam logic [7:0]  DEADZONE_RESET      = 8'd6;

    typedef struct packed {
        logic              start;
        logic [CNT_W-1:0]  steps;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

### rtl/pid_position_regulator.sv
`timescale 1ns / 1ps

// Position PID regulator, one result per control tick. When the joystick
// sits in the deadzone or the joystick scale is zero, the reference
// divide is skipped. A single restoring divider produces one quotient bit
// per cycle (22 bits for the reference, 36 for the scaled output), and
// one shared 17x17 multiplier forms the products, including the divide by
// ten of the leaky sum as a reciprocal multiply. in_ready is high only
// between ticks, so a new tick can be taken in the same cycle the result
// appears; a finished result waits in the output register, so the next
// tick may be taken before it is drained. Registers sit at byte address
// 4*index on the APB-style port; write them only while idle.

module pid_position_regulator
    import pidr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         joy_position,
    input  logic signed [15:0] encoder_sample,

    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] control_value,
    output logic               reverse_dir,
    output logic               saturated
);

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b0000000001,
        ST_REF_MUL   = 10'b0000000010,
        ST_REF_DIV   = 10'b0000000100,
        ST_ERR       = 10'b0000001000,
        ST_LEAK_MUL  = 10'b0000010000,
        ST_MUL_P     = 10'b0000100000,
        ST_MUL_I     = 10'b0001000000,
        ST_MUL_D     = 10'b0010000000,
        ST_ACC_D     = 10'b0100000000,
        ST_TOTAL_DIV = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   finish_reg, finish_next;
    logic   launched_reg, launched_next;

    logic [14:0] gain_p_reg, gain_i_reg, gain_d_reg, output_limit_reg;
    logic [15:0] scale_divisor_reg;
    logic [13:0] encoder_fs_reg;
    logic [7:0]  joystick_fs_reg, deadzone_reg;

    logic [7:0]                joy_reg, joy_next;
    logic signed [15:0]        enc_reg, enc_next;
    logic [REF_W-1:0]          ref_reg, ref_next;
    logic [MAG_W-1:0]          mag_reg, mag_next;
    logic                      rev_reg, rev_next;
    logic signed [LEAK_W-1:0]  sum_reg, sum_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [DIV_W-1:0]          tot_reg, tot_next;
    logic signed [15:0]        error_sum_reg, error_sum_next;
    logic [MAG_W-1:0]          prev_reg, prev_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [15:0]        ctl_reg, ctl_next;
    logic                      odir_reg, odir_next;
    logic                      osat_reg, osat_next;

    logic                      cfg_write;
    reg_index_t                cfg_index;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    logic [13:0]               enc_clamped;
    logic signed [REF_W:0]     err;
    logic [REF_W:0]            err_abs;
    logic signed [17:0]        leak_sum;
    logic                      leak_neg;
    logic [15:0]               leak_abs;
    logic [LEAK_W-1:0]         leak_quot;
    logic [15:0]               diff;
    logic signed [ACC_W-1:0]   prod_ext;
    logic                      tot_neg;
    logic [DIV_W-1:0]          acc_abs;
    logic                      sat;
    logic [14:0]               ctl_mag;
    logic signed [16:0]        backoff;
    logic                      out_free;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_index = reg_index_t'(paddr[4:2]);

    always_comb
    begin
        case (cfg_index)
            REG_GAIN_P:        prdata = {17'd0, gain_p_reg};
            REG_GAIN_I:        prdata = {17'd0, gain_i_reg};
            REG_GAIN_D:        prdata = {17'd0, gain_d_reg};
            REG_OUTPUT_LIMIT:  prdata = {17'd0, output_limit_reg};
            REG_SCALE_DIVISOR: prdata = {16'd0, scale_divisor_reg};
            REG_ENCODER_FS:    prdata = {18'd0, encoder_fs_reg};
            REG_JOYSTICK_FS:   prdata = {24'd0, joystick_fs_reg};
            REG_DEADZONE:      prdata = {24'd0, deadzone_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg        <= GAIN_P_RESET;
            gain_i_reg        <= GAIN_I_RESET;
            gain_d_reg        <= GAIN_D_RESET;
            output_limit_reg  <= OUTPUT_LIMIT_RESET;
            scale_divisor_reg <= SCALE_DIVISOR_RESET;
            encoder_fs_reg    <= ENCODER_FS_RESET;
            joystick_fs_reg   <= JOYSTICK_FS_RESET;
            deadzone_reg      <= DEADZONE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GAIN_P:        gain_p_reg        <= pwdata[14:0];
                REG_GAIN_I:        gain_i_reg        <= pwdata[14:0];
                REG_GAIN_D:        gain_d_reg        <= pwdata[14:0];
                REG_OUTPUT_LIMIT:  output_limit_reg  <= pwdata[14:0];
                REG_SCALE_DIVISOR: scale_divisor_reg <= pwdata[15:0];
                REG_ENCODER_FS:    encoder_fs_reg    <= pwdata[13:0];
                REG_JOYSTICK_FS:   joystick_fs_reg   <= pwdata[7:0];
                REG_DEADZONE:      deadzone_reg      <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    pidr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        case (state_reg)
            ST_REF_MUL:
            begin
                mul_a = {3'd0, encoder_fs_reg};
                mul_b = {9'd0, joy_reg};
            end
            ST_LEAK_MUL:
            begin
                mul_a = {1'b0, LEAK_RECIP};
                mul_b = {1'b0, leak_abs};
            end
            ST_MUL_P:
            begin
                mul_a = {2'd0, gain_p_reg};
                mul_b = {2'd0, mag_reg};
            end
            ST_MUL_I:
            begin
                mul_a = {2'd0, gain_i_reg};
                mul_b = {{(MUL_W-LEAK_W){sum_reg[LEAK_W-1]}}, sum_reg};
            end
            ST_MUL_D:
            begin
                mul_a = {2'd0, gain_d_reg};
                mul_b = {diff[15], diff};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign enc_clamped = enc_reg[15] ? 14'd0 :
                         (enc_reg > 16'sd8500) ? 14'(ENC_CLAMP_MAX) : enc_reg[13:0];
    assign err      = $signed({1'b0, ref_reg}) - $signed({9'd0, enc_clamped});
    assign err_abs  = err[REF_W] ? 23'(-err) : 23'(err);

    assign leak_sum  = 18'(error_sum_reg) + $signed({3'd0, mag_reg});
    assign leak_neg  = leak_sum[17];
    assign leak_abs  = leak_neg ? 16'(-leak_sum) : leak_sum[15:0];
    assign leak_quot = prod_reg[LEAK_SHIFT+LEAK_W-1:LEAK_SHIFT];

    assign diff     = {1'b0, mag_reg} - {1'b0, prev_reg};
    assign prod_ext = ACC_W'(prod_reg);

    assign tot_neg  = acc_reg[ACC_W-1];
    assign acc_abs  = tot_neg ? DIV_W'(-acc_reg) : DIV_W'(acc_reg);

    assign sat      = tot_reg > {21'd0, output_limit_reg};
    assign ctl_mag  = sat ? output_limit_reg : tot_reg[14:0];
    assign backoff  = 17'(sum_reg) - (sat ? $signed({2'd0, mag_reg}) : 17'sd0);
    assign out_free = ~out_valid_reg | out_ready;

    always_comb
    begin
        state_next     = state_reg;
        finish_next    = finish_reg;
        launched_next  = launched_reg;
        joy_next       = joy_reg;
        enc_next       = enc_reg;
        ref_next       = ref_reg;
        mag_next       = mag_reg;
        rev_next       = rev_reg;
        sum_next       = sum_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        tot_next       = tot_reg;
        error_sum_next = error_sum_reg;
        prev_next      = prev_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        ctl_next       = ctl_reg;
        odir_next      = odir_reg;
        osat_next      = osat_reg;
        div_req        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (finish_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        ctl_next       = tot_neg ? -$signed({1'b0, ctl_mag})
                                                 : $signed({1'b0, ctl_mag});
                        odir_next      = rev_reg;
                        osat_next      = sat;
                        prev_next      = mag_reg;
                        if (backoff > 17'sd32767)
                            error_sum_next = 16'sd32767;
                        else if (backoff < -17'sd32768)
                            error_sum_next = -16'sd32768;
                        else
                            error_sum_next = backoff[15:0];
                        finish_next    = 1'b0;
                    end
                end
                else if (in_valid)
                begin
                    joy_next   = joy_position;
                    enc_next   = encoder_sample;
                    state_next = ST_REF_MUL;
                end
            end
            ST_REF_MUL:
            begin
                prod_next = mul_p;
                if (joy_reg < deadzone_reg)
                begin
                    ref_next   = '0;
                    state_next = ST_ERR;
                end
                else if (joystick_fs_reg == '0)
                begin
                    ref_next   = REF_W'(encoder_fs_reg);
                    state_next = ST_ERR;
                end
                else
                begin
                    state_next = ST_REF_DIV;
                end
            end
            ST_REF_DIV:
            begin
                if (!launched_reg)
                begin
                    div_req.start    = 1'b1;
                    div_req.steps    = CNT_W'(REF_STEPS);
                    div_req.dividend = {prod_reg[REF_W-1:0], {(DIV_W-REF_W){1'b0}}};
                    div_req.divisor  = {8'd0, joystick_fs_reg};
                    launched_next    = 1'b1;
                end
                else if (!div_rsp.busy)
                begin
                    ref_next      = div_rsp.quotient[REF_W-1:0];
                    launched_next = 1'b0;
                    state_next    = ST_ERR;
                end
            end
            ST_ERR:
            begin
                rev_next   = err[REF_W];
                mag_next   = (err_abs > 23'd32767) ? 15'h7FFF : err_abs[MAG_W-1:0];
                state_next = ST_LEAK_MUL;
            end
            ST_LEAK_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                sum_next   = leak_neg ? -$signed(leak_quot) : $signed(leak_quot);
                prod_next  = mul_p;
                state_next = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                acc_next   = prod_ext;
                prod_next  = mul_p;
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                acc_next   = acc_reg + prod_ext;
                prod_next  = mul_p;
                state_next = ST_ACC_D;
            end
            ST_ACC_D:
            begin
                acc_next   = acc_reg + (prod_ext <<< 3) + (prod_ext <<< 1);
                state_next = ST_TOTAL_DIV;
            end
            ST_TOTAL_DIV:
            begin
                if (!launched_reg)
                begin
                    div_req.start    = 1'b1;
                    div_req.steps    = CNT_W'(TOTAL_STEPS);
                    div_req.dividend = acc_abs;
                    div_req.divisor  = (scale_divisor_reg == '0) ? DVSR_W'(1)
                                                                 : scale_divisor_reg;
                    launched_next    = 1'b1;
                end
                else if (!div_rsp.busy)
                begin
                    tot_next      = div_rsp.quotient;
                    launched_next = 1'b0;
                    finish_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next    = ST_IDLE;
                launched_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            finish_reg    <= 1'b0;
            launched_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            error_sum_reg <= '0;
            prev_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            finish_reg    <= finish_next;
            launched_reg  <= launched_next;
            out_valid_reg <= out_valid_next;
            error_sum_reg <= error_sum_next;
            prev_reg      <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        joy_reg  <= joy_next;
        enc_reg  <= enc_next;
        ref_reg  <= ref_next;
        mag_reg  <= mag_next;
        rev_reg  <= rev_next;
        sum_reg  <= sum_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        tot_reg  <= tot_next;
        ctl_reg  <= ctl_next;
        odir_reg <= odir_next;
        osat_reg <= osat_next;
    end

    assign in_ready      = (state_reg == ST_IDLE) & ~finish_reg;
    assign out_valid     = out_valid_reg;
    assign control_value = ctl_reg;
    assign reverse_dir   = odir_reg;
    assign saturated     = osat_reg;

endmodule

### rtl/pidr_div.sv
`timescale 1ns / 1ps

module pidr_div
    import pidr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]  q_reg, q_next;
    logic [DVSR_W-1:0] rem_reg, rem_next;
    logic [DVSR_W-1:0] dvsr_reg, dvsr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [DVSR_W:0]   shifted;
    logic [DVSR_W+1:0] trial;
    logic              borrow;

    assign shifted = {rem_reg, q_reg[DIV_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dvsr_reg};
    assign borrow  = trial[DVSR_W+1];

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            q_next    = req.dividend;
            rem_next  = '0;
            dvsr_next = req.divisor;
            cnt_next  = req.steps;
        end
        else if (cnt_reg != '0)
        begin
            rem_next = borrow ? shifted[DVSR_W-1:0] : trial[DVSR_W-1:0];
            q_next   = {q_reg[DIV_W-2:0], ~borrow};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign rsp.busy     = (cnt_reg != '0);
    assign rsp.quotient = q_reg;

endmodule

### tb/pid_position_regulator_test.sv
`timescale 1ns / 1ps

module pid_position_regulator_test;

    import pidr_pkg::*;

    localparam int ERR_LIMIT       = 32767;
    localparam int D_FACTOR        = 10;
    localparam int NUM_PHASES      = 13;
    localparam int TICKS_PER_PHASE = 110;
    localparam int LONG_HOLD       = 600;
    localparam int END_WAIT        = 200;
    localparam int WATCHDOG_LIMIT  = 4000;

    typedef struct packed {
        logic [7:0]         joy;
        logic signed [15:0] enc;
    } tick_input_t;

    typedef struct packed {
        logic signed [15:0] control_value;
        logic               reverse_dir;
        logic               saturated;
    } tick_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         joy_position = '0;
    logic signed [15:0] encoder_sample = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] control_value;
    logic               reverse_dir;
    logic               saturated;

    logic [14:0] cfg_gain_p       = GAIN_P_RESET;
    logic [14:0] cfg_gain_i       = GAIN_I_RESET;
    logic [14:0] cfg_gain_d       = GAIN_D_RESET;
    logic [14:0] cfg_output_limit = OUTPUT_LIMIT_RESET;
    logic [15:0] cfg_scale_div    = SCALE_DIVISOR_RESET;
    logic [13:0] cfg_encoder_fs   = ENCODER_FS_RESET;
    logic [7:0]  cfg_joystick_fs  = JOYSTICK_FS_RESET;
    logic [7:0]  cfg_deadzone     = DEADZONE_RESET;

    int ctrl_error_sum = 0;
    int ctrl_last_mag  = 0;

    tick_input_t  pending_ticks[$];
    tick_result_t expected_outputs[$];
    tick_input_t  next_tick;
    tick_result_t predicted_result;
    tick_result_t expected_result;

    bit send_gaps_on   = 1'b1;
    bit recv_stalls_on = 1'b1;
    int send_gap       = 0;
    int recv_stall     = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;
    int mismatch_count = 0;
    int results_seen   = 0;

    pid_position_regulator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .joy_position   (joy_position),
        .encoder_sample (encoder_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .control_value  (control_value),
        .reverse_dir    (reverse_dir),
        .saturated      (saturated)
    );

    always #5 clk = ~clk;

    function automatic tick_result_t predict_tick(input logic [7:0] joy,
                                                  input logic signed [15:0] enc_in);
        tick_result_t r;
        longint target, pos, err, mag, leak, total, ctl, dvsr;
        longint gp, gi, gd, lim, efs, jfs, jv;
        logic rev, sat;
        gp = cfg_gain_p;
        gi = cfg_gain_i;
        gd = cfg_gain_d;
        lim = cfg_output_limit;
        dvsr = cfg_scale_div;
        efs = cfg_encoder_fs;
        jfs = cfg_joystick_fs;
        jv = joy;
        if (joy < cfg_deadzone)
            target = 0;
        else if (jfs == 0)
            target = efs;
        else
            target = (efs * jv) / jfs;
        pos = enc_in;
        if (pos < 0)
            pos = 0;
        else if (pos > ENC_CLAMP_MAX)
            pos = ENC_CLAMP_MAX;
        err = target - pos;
        rev = err < 0;
        mag = rev ? -err : err;
        if (mag > ERR_LIMIT)
            mag = ERR_LIMIT;
        leak = (longint'(ctrl_error_sum) + mag) / LEAK_DIVISOR;
        if (dvsr == 0)
            dvsr = 1;
        total = (gp * mag + gi * leak + gd * (mag - longint'(ctrl_last_mag)) * D_FACTOR) / dvsr;
        ctrl_last_mag = int'(mag);
        ctl = total;
        sat = 1'b0;
        if (total > lim)
        begin
            ctl = lim;
            sat = 1'b1;
        end
        else if (total < -lim)
        begin
            ctl = -lim;
            sat = 1'b1;
        end
        if (sat)
            leak = leak - mag;
        if (leak < -32768)
            leak = -32768;
        else if (leak > 32767)
            leak = 32767;
        ctrl_error_sum = int'(leak);
        r.control_value = 16'(ctl);
        r.reverse_dir = rev;
        r.saturated = sat;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 200);
    endfunction

    function automatic int pick_field(input int maxv);
        case ($urandom_range(0, 7))
            0: return 0;
            1: return maxv;
            2, 3: return $urandom_range(0, 64);
            default: return $urandom_range(0, maxv);
        endcase
    endfunction

    function automatic logic signed [15:0] noise_sample();
        case ($urandom_range(0, 3))
            0: return 16'($urandom());
            1: return 16'($urandom_range(0, ENC_CLAMP_MAX));
            2: return 16'($urandom_range(0, 16383));
            default:
                case ($urandom_range(0, 5))
                    0: return 16'sh8000;
                    1: return -16'sd1;
                    2: return 16'sd0;
                    3: return 16'(ENC_CLAMP_MAX);
                    4: return 16'(ENC_CLAMP_MAX + 1);
                    default: return 16'sh7fff;
                endcase
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t, result %0d: %s", $time, results_seen, what);
    endtask

    task automatic push_tick(input logic [7:0] joy, input logic signed [15:0] enc);
        tick_input_t t;
        t.joy = joy;
        t.enc = enc;
        pending_ticks.push_back(t);
    endtask

    task automatic apb_write(input reg_index_t idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_GAIN_P:        cfg_gain_p = value[14:0];
            REG_GAIN_I:        cfg_gain_i = value[14:0];
            REG_GAIN_D:        cfg_gain_d = value[14:0];
            REG_OUTPUT_LIMIT:  cfg_output_limit = value[14:0];
            REG_SCALE_DIVISOR: cfg_scale_div = value[15:0];
            REG_ENCODER_FS:    cfg_encoder_fs = value[13:0];
            REG_JOYSTICK_FS:   cfg_joystick_fs = value[7:0];
            REG_DEADZONE:      cfg_deadzone = value[7:0];
            default:           ;
        endcase
    endtask

    task automatic apply_config(input int gp, input int gi, input int gd, input int lim,
                                input int dvsr, input int efs, input int jfs, input int dz);
        apb_write(REG_GAIN_P, gp);
        apb_write(REG_GAIN_I, gi);
        apb_write(REG_GAIN_D, gd);
        apb_write(REG_OUTPUT_LIMIT, lim);
        apb_write(REG_SCALE_DIVISOR, dvsr);
        apb_write(REG_ENCODER_FS, efs);
        apb_write(REG_JOYSTICK_FS, jfs);
        apb_write(REG_DEADZONE, dz);
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (pending_ticks.size() != 0 || expected_outputs.size() != 0 || in_valid);
    endtask

    task automatic queue_random_ticks(input int count);
        int left, run, k, joy, pos, aim;
        left = count;
        while (left > 0)
        begin
            if ($urandom_range(0, 9) < 6)
            begin
                // track a stick setting with a settling position
                run = $urandom_range(8, 40);
                joy = $urandom_range(0, 255);
                pos = $urandom_range(0, ENC_CLAMP_MAX);
                for (k = 0; k < run && left > 0; k++)
                begin
                    if ($urandom_range(0, 7) == 0)
                        joy = $urandom_range(0, 255);
                    aim = joy * 33;
                    pos = pos + (aim - pos) / int'($urandom_range(2, 8))
                          + int'($urandom_range(0, 40)) - 20;
                    push_tick(8'(joy), 16'(pos));
                    left--;
                end
            end
            else
            begin
                push_tick(8'($urandom_range(0, 255)), noise_sample());
                left--;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            joy_position <= '0;
            encoder_sample <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predicted_result = predict_tick(joy_position, encoder_sample);
                expected_outputs.push_back(predicted_result);
            end
            // hold payload until transfer
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_ticks.size() > 0)
                begin
                    next_tick = pending_ticks.pop_front();
                    in_valid <= 1'b1;
                    joy_position <= next_tick.joy;
                    encoder_sample <= next_tick.enc;
                    send_gap <= send_gaps_on ? pick_gap() : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_stall <= 0;
            hold_left <= 0;
            hold_served <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_outputs.size() == 0)
                begin
                    report_mismatch("result with no tick pending");
                end
                else
                begin
                    expected_result = expected_outputs.pop_front();
                    if (control_value !== expected_result.control_value)
                        report_mismatch($sformatf("control_value %0d, expected %0d",
                                                  control_value,
                                                  expected_result.control_value));
                    if (reverse_dir !== expected_result.reverse_dir)
                        report_mismatch($sformatf("reverse_dir %0b, expected %0b",
                                                  reverse_dir, expected_result.reverse_dir));
                    if (saturated !== expected_result.saturated)
                        report_mismatch($sformatf("saturated %0b, expected %0b",
                                                  saturated, expected_result.saturated));
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served <= hold_served + 1;
                hold_left <= LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall <= recv_stall - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (recv_stalls_on && $urandom_range(0, 3) == 0)
                    recv_stall <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_tick(8'd0, 16'sd0);
        push_tick(8'd5, 16'sd0);
        push_tick(8'd6, 16'sd0);
        push_tick(8'd255, 16'sd8500);
        push_tick(8'd255, 16'sh8000);
        push_tick(8'd0, 16'sh7fff);
        push_tick(8'd0, -16'sd1);
        push_tick(8'd128, 16'sd4250);
        push_tick(8'd255, 16'sd8501);
        push_tick(8'd0, 16'sd8500);
        push_tick(8'd255, 16'sd0);
        push_tick(8'd255, 16'sd0);
        push_tick(8'hAA, 16'sh5555);
        push_tick(8'h55, 16'shAAAA);
        push_tick(8'd7, 16'sd100);
        push_tick(8'd200, 16'sd6000);
        queue_random_ticks(80);
        wait_for_drain();

        for (int phase = 1; phase <= NUM_PHASES; phase++)
        begin
            case (phase)
                1: apply_config(32767, 32767, 32767, 32767, 65535, 16383, 255, 255);
                2: apply_config(0, 0, 0, 0, 0, 0, 0, 0);
                3: apply_config(32767, 32767, 32767, 0, 0, 8500, 0, 0);
                4: apply_config(1, 1, 1, 32767, 1, 16383, 1, 0);
                5: apply_config(10, 6, 1, 4095, 100, 8500, 255, 6);
                6: apply_config(200, 50, 20, 1, 1, 8500, 255, 0);
                default: apply_config(pick_field(32767), pick_field(32767), pick_field(32767),
                                      pick_field(32767), pick_field(65535), pick_field(16383),
                                      pick_field(255), pick_field(255));
            endcase
            send_gaps_on = (phase != 2 && phase != 6) && ($urandom_range(0, 3) != 0);
            recv_stalls_on = (phase != 2 && phase != 6) && ($urandom_range(0, 3) != 0);
            if (phase == 5 || phase == 9)
                hold_requests = hold_requests + 1;
            queue_random_ticks(TICKS_PER_PHASE);
            wait_for_drain();
        end

        repeat (END_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
